/* hw/rtl/srrw_pkg.sv */
`timescale 1ns / 1ps

package srrw_pkg;

  localparam int unsigned SEQ_W   = 32;
  localparam int unsigned LEN_W   = 10;
  localparam int unsigned OFFS_W  = 42;
  localparam int unsigned WSIZE_W = 7;
  localparam int unsigned CHUNK_W = 16;

  // Hard ceiling of the received bitmap
  localparam int unsigned MAP_LIMIT = 64;

  localparam int unsigned WINDOW_MAX_DEF  = 64;
  localparam int unsigned CHUNK_BYTES_DEF = 1000;
  localparam logic [WSIZE_W-1:0] WSIZE_RESET = WSIZE_W'(8);

  // Stream payload widths, rounded up to whole bytes
  localparam int unsigned IN_TDATA_W  = 48;
  localparam int unsigned OUT_TDATA_W = 112;

  typedef struct packed {
    logic              accepted;
    logic [SEQ_W-1:0]  ack_number;
    logic [OFFS_W-1:0] write_offset;
    logic              last_seen;
    logic [SEQ_W-1:0]  window_base;
  } res_t;

endpackage

/* hw/rtl/srrw_slide.sv */
`timescale 1ns / 1ps

module srrw_slide #(
  parameter int unsigned MapW = 64,
  parameter int unsigned IdxW = 6,
  parameter int unsigned RunW = 7
) (
  input  logic [MapW-1:0] map_i,
  input  logic [IdxW-1:0] slot_i,
  input  logic [RunW-1:0] wsize_i,
  output logic [MapW-1:0] map_o,
  output logic [RunW-1:0] run_o
);

  logic [MapW-1:0] set_map;
  logic [MapW-1:0] first_zero;
  logic [RunW-1:0] run_raw;

  assign set_map    = map_i | (MapW'(1) << slot_i);
  // One-hot marker of the lowest clear bit; zero when the map is full
  assign first_zero = ~set_map & (set_map + MapW'(1));

  always_comb begin
    run_raw = '0;
    for (int unsigned i = 0; i < MapW; i++) begin
      run_raw = run_raw | (first_zero[i] ? RunW'(i) : RunW'(0));
    end
    if (first_zero == '0) begin
      run_raw = RunW'(MapW);
    end
  end

  // Never slide past the window end
  assign run_o = (run_raw < wsize_i) ? run_raw : wsize_i;
  assign map_o = set_map >> run_o;

endmodule

/* hw/rtl/srrw_window.sv */
`timescale 1ns / 1ps

module srrw_window
  import srrw_pkg::*;
#(
  parameter int unsigned WINDOW_MAX  = WINDOW_MAX_DEF,
  parameter int unsigned CHUNK_BYTES = CHUNK_BYTES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [WSIZE_W-1:0] cfg_data_i,
  input  logic               step_i,
  input  logic [SEQ_W-1:0]   seq_i,
  input  logic [LEN_W-1:0]   len_i,
  output res_t               res_o
);

  localparam int unsigned MapW = (WINDOW_MAX > MAP_LIMIT) ? MAP_LIMIT : WINDOW_MAX;
  localparam int unsigned IdxW = (MapW > 1) ? $clog2(MapW) : 1;
  localparam int unsigned RunW = $clog2(MapW + 1);
  localparam logic [WSIZE_W:0]   MapWL  = (WSIZE_W + 1)'(MapW);
  localparam logic [CHUNK_W-1:0] ChunkC = CHUNK_W'(CHUNK_BYTES);

  logic [WSIZE_W-1:0]       wsize_q;
  logic [MapW-1:0]          map_q, map_d;
  logic [SEQ_W-1:0]         base_q, base_d;
  logic                     done_q, done_d;

  logic [WSIZE_W:0]         wsize_full, wsize_eff;
  logic [SEQ_W-1:0]         slot;
  logic                     hit, short_pkt;
  logic [MapW-1:0]          slid_map;
  logic [RunW-1:0]          run;
  logic [SEQ_W+CHUNK_W-1:0] product;

  assign wsize_full = {1'b0, wsize_q};
  assign wsize_eff  = (wsize_full > MapWL) ? MapWL : wsize_full;
  assign slot       = seq_i - base_q;
  assign hit        = !done_q && (slot < SEQ_W'(wsize_eff));
  assign short_pkt  = CHUNK_W'(len_i) < ChunkC;
  assign product    = (SEQ_W + CHUNK_W)'(seq_i) * (SEQ_W + CHUNK_W)'(ChunkC);

  srrw_slide #(
    .MapW (MapW),
    .IdxW (IdxW),
    .RunW (RunW)
  ) u_slide (
    .map_i   (map_q),
    .slot_i  (slot[IdxW-1:0]),
    .wsize_i (RunW'(wsize_eff)),
    .map_o   (slid_map),
    .run_o   (run)
  );

  always_comb begin
    map_d  = map_q;
    base_d = base_q;
    done_d = done_q;
    if (step_i) begin
      if (hit) begin
        map_d  = slid_map;
        base_d = base_q + SEQ_W'(run);
      end
      if (!done_q && short_pkt) begin
        done_d = 1'b1;
      end
    end
  end

  always_comb begin
    res_o.accepted     = hit;
    res_o.ack_number   = hit ? (seq_i + SEQ_W'(1)) : '0;
    res_o.write_offset = hit ? product[OFFS_W-1:0] : '0;
    res_o.last_seen    = done_q || short_pkt;
    res_o.window_base  = hit ? (base_q + SEQ_W'(run)) : base_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wsize_q <= WSIZE_RESET;
      map_q   <= '0;
      base_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        wsize_q <= cfg_data_i;
      end
      map_q  <= map_d;
      base_q <= base_d;
      done_q <= done_d;
    end
  end

endmodule

/* hw/rtl/selective_repeat_receive_window.sv */
`timescale 1ns / 1ps

// Selective-repeat receive window. Each packet header (sequence number and
// payload length) is checked against the window [base, base + window length);
// a packet inside it sets its slot in the received bitmap, the unbroken run
// of received slots at the window start is shifted out, and the base moves
// up by that run. The result reports acceptance, the ack number (seq + 1),
// the byte offset seq * CHUNK_BYTES, the end-of-transfer flag and the new
// base. A payload shorter than CHUNK_BYTES ends the transfer; every later
// packet is rejected. Throughput is one header per clock while results
// are taken: a header sits in the input register, the window state
// updates at the edge it moves to the result register, and the next
// header may follow right away. A header passes the input register and then
// the result register before m_axis_tvalid rises. The cycle is set by the
// bitmap slide (lowest-zero search and barrel shift over min(WINDOW_MAX, 64)
// bits) in series with the window compare. While a result waits on
// m_axis_tready the input register takes at most one more header and then
// holds s_axis_tready low. Write the window length (1..64, reset 8) only
// while no header is in flight.
module selective_repeat_receive_window
  import srrw_pkg::*;
#(
  parameter int unsigned WINDOW_MAX  = WINDOW_MAX_DEF,
  parameter int unsigned CHUNK_BYTES = CHUNK_BYTES_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Configuration write: window length
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [WSIZE_W-1:0]     cfg_data_i,
  // Packet headers
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // seq_number [31:0], payload_len [41:32], zero pad [47:42]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // Results
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // accepted [0], ack_number [32:1], write_offset [74:33], last_seen [75],
  // window_base [107:76], zero pad [111:108]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  localparam int unsigned ResW = $bits(res_t);

  logic             in_valid_q;
  logic [SEQ_W-1:0] seq_q;
  logic [LEN_W-1:0] len_q;
  logic             out_valid_q;
  res_t             res_q;
  res_t             res;
  logic             out_free;
  logic             advance;

  // The result register empties or is being drained this cycle
  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;
  assign cfg_ready_o   = 1'b1;

  // Input register: hold the header until the result register takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      seq_q <= s_axis_tdata[SEQ_W-1:0];
      len_q <= s_axis_tdata[SEQ_W+LEN_W-1:SEQ_W];
    end
  end

  // Window state; it advances exactly when a header moves to the result side
  srrw_window #(
    .WINDOW_MAX  (WINDOW_MAX),
    .CHUNK_BYTES (CHUNK_BYTES)
  ) u_window (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .step_i     (advance),
    .seq_i      (seq_q),
    .len_i      (len_q),
    .res_o      (res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {
    (OUT_TDATA_W - ResW)'(0),
    res_q.window_base,
    res_q.last_seen,
    res_q.write_offset,
    res_q.ack_number,
    res_q.accepted
  };

endmodule

/* hw/rtl/srrw_checker.sv */
`timescale 1ns / 1ps

module srrw_checker
  import srrw_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  logic             acc;
  logic [SEQ_W-1:0] ack;
  logic [OFFS_W-1:0] offs;
  logic             last;
  logic [SEQ_W-1:0] base;
  logic             out_xfer;
  logic             done_seen_q;
  logic [SEQ_W-1:0] base_seen_q;

  assign acc      = m_axis_tdata[0];
  assign ack      = m_axis_tdata[32:1];
  assign offs     = m_axis_tdata[74:33];
  assign last     = m_axis_tdata[75];
  assign base     = m_axis_tdata[107:76];
  assign out_xfer = m_axis_tvalid && m_axis_tready;

  // Track what the delivered result stream has shown so far
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_seen_q <= 1'b0;
      base_seen_q <= '0;
    end else if (out_xfer) begin
      done_seen_q <= done_seen_q || last;
      base_seen_q <= base;
    end
  end

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !acc |-> (ack == '0) && (offs == '0))
    else $error("rejected result carries nonzero ack or offset");

  a_done_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && done_seen_q |-> last && !acc)
    else $error("packet taken or end flag dropped after end of transfer");

  a_base_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !acc |-> base == base_seen_q)
    else $error("window base moved on a rejected packet");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

endmodule

bind selective_repeat_receive_window srrw_checker u_srrw_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
